### hw/rtl/lr_pkg.sv
// Shared types and constants for the line rasterizer.
package lr_pkg;

    localparam int COORD_BITS  = 11;
    localparam int ERR_BITS    = COORD_BITS + 3;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    typedef logic [COORD_BITS-1:0] coord_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } color_t;

    typedef struct packed {
        logic       op;
        coord_t     x_start;
        coord_t     y_start;
        coord_t     x_end;
        coord_t     y_end;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] alpha_in;
    } cmd_item_t;

    typedef struct packed {
        coord_t     pixel_x;
        coord_t     pixel_y;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic [7:0] alpha_out;
        logic       last_pixel;
    } pix_item_t;

    // A classified command as it sits in the queue.
    typedef struct packed {
        logic   is_load;
        coord_t x0;
        coord_t y0;
        coord_t major_end;
        logic   major_is_y;
        logic   y_descends;
        coord_t delta_major;
        coord_t delta_minor;
        color_t color;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

### hw/rtl/lr_cmd_if.sv
// Command channel interface: valid, ready and one command item.
interface lr_cmd_if;
    logic                  valid;
    logic                  ready;
    lr_pkg::cmd_item_t     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/lr_pix_if.sv
// Pixel channel interface: valid, ready and one pixel item.
interface lr_pix_if;
    logic                  valid;
    logic                  ready;
    lr_pkg::pix_item_t     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/line_rasterizer.sv
// Top level of the line rasterizer: front end, job queue and stepping back end.
//
//   Channel   Direction   Transaction
//   cmd       in          one load (endpoints and color) or one tick
//   pixel     out         one pixel position with color and last flag
//
// Sustained rate is one command per clock and one pixel per clock while pixel is ready; the
// stepping unit in the back end does one add, compare and increment a cycle.
// A tick that produces a pixel is written into the queue and then into the back end's
// output register before it shows on pixel.
// Reset clears the queue, the output valid flag and the active line.
// A four-entry queue lets cmd keep flowing while pixel is stalled.
module line_rasterizer (
    input  logic    clk,
    input  logic    rst_n,
    lr_cmd_if.sink  cmd,
    lr_pix_if.source pixel
);

    lr_pkg::q_status_t  q_status;
    lr_pkg::job_t       push_job;
    lr_pkg::job_t       head_job;
    logic               push;
    logic               pop;

    lr_front u_front (
        .cmd      (cmd),
        .q_status (q_status),
        .push     (push),
        .job      (push_job)
    );

    lr_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (q_status)
    );

    lr_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head_job (head_job),
        .pop      (pop),
        .pixel    (pixel)
    );

`ifndef SYNTHESIS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("back end popped an empty queue");

    a_full_drains: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |=> !q_status.empty)
        else $error("full queue became empty in one cycle");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        (q_status.full && !pop) |=> q_status.full)
        else $error("queue left the full state without a pop");
`endif

endmodule

### hw/rtl/lr_front.sv
// Front end: accepts commands and classifies loads into line setup jobs.
module lr_front (
    lr_cmd_if.sink              cmd,
    input  lr_pkg::q_status_t   q_status,
    output logic                push,
    output lr_pkg::job_t        job
);

    lr_pkg::coord_t x0, y0, x1, y1, dx, dy;
    logic           swap, y_desc;

    assign cmd.ready = !q_status.full;
    assign push      = cmd.valid && !q_status.full;

    always_comb
    begin
        // Order the endpoints so that x never decreases along the line.
        swap   = cmd.data.x_end < cmd.data.x_start;
        x0     = swap ? cmd.data.x_end   : cmd.data.x_start;
        y0     = swap ? cmd.data.y_end   : cmd.data.y_start;
        x1     = swap ? cmd.data.x_start : cmd.data.x_end;
        y1     = swap ? cmd.data.y_start : cmd.data.y_end;
        dx     = x1 - x0;
        y_desc = y1 < y0;
        dy     = y_desc ? (y0 - y1) : (y1 - y0);

        job.is_load     = (cmd.data.op == lr_pkg::OP_LOAD);
        job.x0          = x0;
        job.y0          = y0;
        job.y_descends  = y_desc;
        // Equal extents count as steep.
        job.major_is_y  = (dy >= dx);
        job.major_end   = job.major_is_y ? y1 : x1;
        job.delta_major = job.major_is_y ? dy : dx;
        job.delta_minor = job.major_is_y ? dx : dy;
        job.color.red   = cmd.data.red_in;
        job.color.green = cmd.data.green_in;
        job.color.blue  = cmd.data.blue_in;
        job.color.alpha = cmd.data.alpha_in;
    end

endmodule

### hw/rtl/lr_queue.sv
// Short first-in first-out queue of jobs between the front and back ends.
module lr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lr_pkg::job_t        push_job,
    input  logic                pop,
    output lr_pkg::job_t        head_job,
    output lr_pkg::q_status_t   status
);

    lr_pkg::job_t                   entry_reg [lr_pkg::QUEUE_DEPTH];
    logic [lr_pkg::QPTR_BITS-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lr_pkg::QPTR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lr_pkg::QCNT_BITS-1:0]   count_reg, count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == lr_pkg::QCNT_BITS'(lr_pkg::QUEUE_DEPTH));
    assign head_job     = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

### hw/rtl/lr_back.sv
// Back end: holds the line state, steps Bresenham and drives the pixel register.
module lr_back (
    input  logic                clk,
    input  logic                rst_n,
    input  lr_pkg::q_status_t   q_status,
    input  lr_pkg::job_t        head_job,
    output logic                pop,
    lr_pix_if.source            pixel
);

    logic                           active_reg, active_next;
    lr_pkg::coord_t                 cur_x_reg, cur_x_next;
    lr_pkg::coord_t                 cur_y_reg, cur_y_next;
    lr_pkg::coord_t                 major_end_reg, major_end_next;
    logic                           major_is_y_reg, major_is_y_next;
    logic                           y_desc_reg, y_desc_next;
    lr_pkg::coord_t                 d_major_reg, d_major_next;
    lr_pkg::coord_t                 d_minor_reg, d_minor_next;
    logic signed [lr_pkg::ERR_BITS-1:0] err_reg, err_next;
    lr_pkg::color_t                 color_reg, color_next;
    logic                           out_valid_reg, out_valid_next;
    lr_pkg::pix_item_t              out_data_reg, out_data_next;

    logic                           out_free, emit, last, minor_step;
    lr_pkg::coord_t                 y_stepped, x_stepped;
    logic signed [lr_pkg::ERR_BITS-1:0] err_sum;

    assign pixel.valid = out_valid_reg;
    assign pixel.data  = out_data_reg;

    assign out_free = !out_valid_reg || pixel.ready;
    // A load or an idle tick never needs the output register.
    assign pop  = !q_status.empty && (head_job.is_load || !active_reg || out_free);
    assign emit = pop && !head_job.is_load && active_reg;

    always_comb
    begin
        last       = major_is_y_reg ? (cur_y_reg == major_end_reg)
                                    : (cur_x_reg == major_end_reg);
        x_stepped  = cur_x_reg + 1'b1;
        y_stepped  = y_desc_reg ? cur_y_reg - 1'b1 : cur_y_reg + 1'b1;
        err_sum    = err_reg + $signed({2'b00, d_minor_reg, 1'b0});
        minor_step = (err_sum >= $signed({3'b000, d_major_reg}));

        active_next     = active_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        major_end_next  = major_end_reg;
        major_is_y_next = major_is_y_reg;
        y_desc_next     = y_desc_reg;
        d_major_next    = d_major_reg;
        d_minor_next    = d_minor_reg;
        err_next        = err_reg;
        color_next      = color_reg;

        if (pop && head_job.is_load)
        begin
            active_next     = 1'b1;
            cur_x_next      = head_job.x0;
            cur_y_next      = head_job.y0;
            major_end_next  = head_job.major_end;
            major_is_y_next = head_job.major_is_y;
            y_desc_next     = head_job.y_descends;
            d_major_next    = head_job.delta_major;
            d_minor_next    = head_job.delta_minor;
            err_next        = '0;
            color_next      = head_job.color;
        end
        else if (emit)
        begin
            if (last)
            begin
                active_next = 1'b0;
            end
            else
            begin
                err_next = minor_step ? err_sum - $signed({2'b00, d_major_reg, 1'b0})
                                      : err_sum;
                if (major_is_y_reg)
                begin
                    cur_y_next = y_stepped;
                    cur_x_next = minor_step ? x_stepped : cur_x_reg;
                end
                else
                begin
                    cur_x_next = x_stepped;
                    cur_y_next = minor_step ? y_stepped : cur_y_reg;
                end
            end
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.pixel_x    = cur_x_reg;
            out_data_next.pixel_y    = cur_y_reg;
            out_data_next.red_out    = color_reg.red;
            out_data_next.green_out  = color_reg.green;
            out_data_next.blue_out   = color_reg.blue;
            out_data_next.alpha_out  = color_reg.alpha;
            out_data_next.last_pixel = last;
        end
        else if (pixel.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg      <= cur_x_next;
        cur_y_reg      <= cur_y_next;
        major_end_reg  <= major_end_next;
        major_is_y_reg <= major_is_y_next;
        y_desc_reg     <= y_desc_next;
        d_major_reg    <= d_major_next;
        d_minor_reg    <= d_minor_next;
        err_reg        <= err_next;
        color_reg      <= color_next;
        out_data_reg   <= out_data_next;
    end

endmodule
